/* rtl/mrfe_pkg.sv */
// ----------------------------------------------------------------------------
// Motor request frame encoder package
// Command and frame beat types, command codes, identifier type codes and the
// constants of the set-point coders.
// ----------------------------------------------------------------------------
package mrfe_pkg;

	typedef struct packed {
		logic [3:0]         command;
		logic [7:0]         motor_node_id;
		logic [7:0]         new_node_id;
		logic [7:0]         baud_code;
		logic [15:0]        param_index;
		logic [31:0]        param_value;
		logic signed [31:0] torque_target;
		logic signed [31:0] position_target;
		logic signed [31:0] velocity_target;
		logic signed [31:0] stiffness_gain;
		logic signed [31:0] damping_gain;
	} mrfe_cmd_t;

	typedef struct packed {
		logic [28:0] frame_id;
		logic [3:0]  frame_length;
		logic [63:0] frame_payload;
		logic        bad_command;
	} mrfe_frame_t;

	localparam logic [3:0] CMD_DEVID    = 4'd0;
	localparam logic [3:0] CMD_OPCTRL   = 4'd1;
	localparam logic [3:0] CMD_STOP     = 4'd2;
	localparam logic [3:0] CMD_CLRFAULT = 4'd3;
	localparam logic [3:0] CMD_ENABLE   = 4'd4;
	localparam logic [3:0] CMD_CHGID    = 4'd5;
	localparam logic [3:0] CMD_ZERO     = 4'd6;
	localparam logic [3:0] CMD_FAULT    = 4'd7;
	localparam logic [3:0] CMD_BAUD     = 4'd8;
	localparam logic [3:0] CMD_RDPARAM  = 4'd9;
	localparam logic [3:0] CMD_WRPARAM  = 4'd10;

	localparam logic [4:0] TYPE_DEVID   = 5'd0;
	localparam logic [4:0] TYPE_OPCTRL  = 5'd1;
	localparam logic [4:0] TYPE_ENABLE  = 5'd3;
	localparam logic [4:0] TYPE_STOP    = 5'd4;
	localparam logic [4:0] TYPE_ZERO    = 5'd6;
	localparam logic [4:0] TYPE_CHGID   = 5'd7;
	localparam logic [4:0] TYPE_RDPARAM = 5'd17;
	localparam logic [4:0] TYPE_WRPARAM = 5'd18;
	localparam logic [4:0] TYPE_FAULT   = 5'd21;
	localparam logic [4:0] TYPE_BAUD    = 5'd22;

	localparam logic [3:0] LEN_NONE = 4'd0;
	localparam logic [3:0] LEN_FULL = 4'd8;
	localparam logic [7:0] FLAG_ON  = 8'h01;

	// Set-points in order: torque, position, velocity, kp, kd.
	// Span is DIV * 2**(SHIFT-1) with DIV odd; RECIP is floor(2**M_W / DIV).
	localparam int SP_N   = 5;
	localparam int SP_D_W = 25;
	localparam int SP_N_W = 42;
	localparam int SP_R_W = 17;
	localparam int SP_LO    [SP_N] = '{-786432, -823550, -1966080, 0, 0};
	localparam int SP_HI    [SP_N] = '{786432, 823550, 1966080, 32768000, 327680};
	localparam int SP_SHIFT [SP_N] = '{20, 3, 19, 19, 17};
	localparam int SP_DIV   [SP_N] = '{3, 411775, 15, 125, 5};
	localparam int SP_M_W   [SP_N] = '{18, 35, 20, 23, 19};
	localparam int SP_RECIP [SP_N] = '{87381, 83442, 69905, 67108, 104857};

endpackage

/* rtl/motor_request_frame_encoder.sv */
// ----------------------------------------------------------------------------
// Motor request frame encoder
// Turns one command beat into one extended-ID CAN request frame for a servo
// motor, with set-point coding for operation control.
// ----------------------------------------------------------------------------
// The block takes one command beat per cycle unless the output stalls, and
// passes its frame beat through an input register, a register after the clip and
// offset of each set-point, a register after the reciprocal multiply, and the
// result register after the remainder correction. Set-point division by the
// range is done by constant reciprocal multiply and one correction step. The
// stages stall together from the output back, so a waiting result never holds
// up an earlier stage that still has room.
module motor_request_frame_encoder
	import mrfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  mrfe_cmd_t   cmd,
	output logic        frame_valid,
	input  logic        frame_ready,
	output mrfe_frame_t frame
);

	logic [7:0] host_q;

	logic        v_s1, v_s2, v_s3;
	logic        acc_s1, acc_s2, acc_s3, acc_o;
	mrfe_cmd_t   cmd_s1;
	mrfe_frame_t base_s1, base_s2, base_s3;
	logic        op_s1, op_s2, op_s3;
	logic signed [31:0] sp_s1 [SP_N];
	logic [15:0] code [SP_N];
	mrfe_frame_t frame_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_q <= '0;
		end else if (cfg_valid) begin
			host_q <= cfg_data;
		end
	end

	assign acc_o     = !frame_valid || frame_ready;
	assign acc_s3    = !v_s3 || acc_o;
	assign acc_s2    = !v_s2 || acc_s3;
	assign acc_s1    = !v_s1 || acc_s2;
	assign cmd_ready = acc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			frame_valid <= 1'b0;
		end else begin
			if (acc_s1) v_s1 <= cmd_valid;
			if (acc_s2) v_s2 <= v_s1;
			if (acc_s3) v_s3 <= v_s2;
			if (acc_o)  frame_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_s1) cmd_s1 <= cmd;
		if (acc_s2) begin
			base_s2 <= base_s1;
			op_s2   <= op_s1;
		end
		if (acc_s3) begin
			base_s3 <= base_s2;
			op_s3   <= op_s2;
		end
		if (acc_o) frame <= frame_d;
	end

	// Fixed part of the frame
	always_comb begin
		base_s1               = '0;
		base_s1.frame_length  = LEN_FULL;
		base_s1.frame_id[7:0] = cmd_s1.motor_node_id;
		base_s1.frame_id[15:8] = host_q;
		op_s1                 = 1'b0;
		case (cmd_s1.command)
			CMD_DEVID: begin
				base_s1.frame_id[28:24] = TYPE_DEVID;
				base_s1.frame_length    = LEN_NONE;
			end
			CMD_OPCTRL: begin
				base_s1.frame_id[28:24] = TYPE_OPCTRL;
				base_s1.frame_id[15:8]  = '0;
				op_s1                   = 1'b1;
			end
			CMD_STOP: begin
				base_s1.frame_id[28:24] = TYPE_STOP;
			end
			CMD_CLRFAULT: begin
				base_s1.frame_id[28:24]      = TYPE_STOP;
				base_s1.frame_payload[63:56] = FLAG_ON;
			end
			CMD_ENABLE: begin
				base_s1.frame_id[28:24] = TYPE_ENABLE;
			end
			CMD_CHGID: begin
				base_s1.frame_id[28:24]      = TYPE_CHGID;
				base_s1.frame_id[23:16]      = cmd_s1.new_node_id;
				base_s1.frame_payload[63:56] = FLAG_ON;
			end
			CMD_ZERO: begin
				base_s1.frame_id[28:24]      = TYPE_ZERO;
				base_s1.frame_payload[63:56] = FLAG_ON;
			end
			CMD_FAULT: begin
				base_s1.frame_id[28:24] = TYPE_FAULT;
			end
			CMD_BAUD: begin
				base_s1.frame_id[28:24]      = TYPE_BAUD;
				base_s1.frame_payload[63:56] = cmd_s1.baud_code;
			end
			CMD_RDPARAM: begin
				base_s1.frame_id[28:24]      = TYPE_RDPARAM;
				base_s1.frame_payload[63:48] = {cmd_s1.param_index[7:0],
					cmd_s1.param_index[15:8]};
			end
			CMD_WRPARAM: begin
				base_s1.frame_id[28:24]      = TYPE_WRPARAM;
				base_s1.frame_payload[63:48] = {cmd_s1.param_index[7:0],
					cmd_s1.param_index[15:8]};
				base_s1.frame_payload[31:0]  = {cmd_s1.param_value[7:0],
					cmd_s1.param_value[15:8], cmd_s1.param_value[23:16],
					cmd_s1.param_value[31:24]};
			end
			default: begin
				base_s1             = '0;
				base_s1.bad_command = 1'b1;
			end
		endcase
	end

	assign sp_s1[0] = cmd_s1.torque_target;
	assign sp_s1[1] = cmd_s1.position_target;
	assign sp_s1[2] = cmd_s1.velocity_target;
	assign sp_s1[3] = cmd_s1.stiffness_gain;
	assign sp_s1[4] = cmd_s1.damping_gain;

	for (genvar c = 0; c < SP_N; c++) begin : g_sp
		localparam int LO    = SP_LO[c];
		localparam int HI    = SP_HI[c];
		localparam int SPAN  = HI - LO;
		localparam int SHIFT = SP_SHIFT[c];
		localparam int DIV   = SP_DIV[c];
		localparam int MW    = SP_M_W[c];
		localparam int RECIP = SP_RECIP[c];

		logic signed [31:0]       clip;
		logic [SP_D_W-1:0]        d;
		logic [SP_N_W-1:0]        n;
		logic [MW-1:0]            m_s2, m_s3;
		logic [MW+SP_R_W-1:0]     prod;
		logic [15:0]              qe_s3;
		logic [MW+16-1:0]         qs;
		logic [MW-1:0]            r;
		logic [16:0]              qinc;

		// Clip, offset to zero, then 2*d*65535 + span
		always_comb begin
			if (sp_s1[c] < LO) begin
				clip = 32'(LO);
			end else if (sp_s1[c] > HI) begin
				clip = 32'(HI);
			end else begin
				clip = sp_s1[c];
			end
		end

		assign d = SP_D_W'(clip - 32'(LO));
		assign n = (SP_N_W'(d) << 17) - (SP_N_W'(d) << 1) + SP_N_W'(SPAN);

		assign prod = (MW+SP_R_W)'(m_s2) * (MW+SP_R_W)'(RECIP);

		always_ff @(posedge clk) begin
			if (acc_s2) m_s2 <= n[SHIFT +: MW];
			if (acc_s3) begin
				m_s3  <= m_s2;
				qe_s3 <= prod[MW +: 16];
			end
		end

		// Estimate is exact or one short
		assign qs      = (MW+16)'(qe_s3) * (MW+16)'(DIV);
		assign r       = m_s3 - qs[MW-1:0];
		assign qinc    = 17'(qe_s3) + 17'd1;
		assign code[c] = (r >= MW'(DIV)) ? qinc[15:0] : qe_s3;
	end

	always_comb begin
		frame_d = base_s3;
		if (op_s3) begin
			frame_d.frame_id[23:8] = code[0];
			frame_d.frame_payload  = {code[1], code[2], code[3], code[4]};
		end
	end

endmodule
